FILE: hdl/rth_pkg.sv
// Shared types and constants for the RGB to HSL converter.
package rth_pkg;

    localparam int CH_W     = 8;
    localparam int HUE_W    = 9;
    localparam int DEN_W    = 10;
    localparam int SUM_W    = 9;
    localparam int FULL_SUM = 510;
    localparam int HALF_SUM = 255;

    localparam int LIT_X_W         = 16;
    localparam int LIT_PROD_W      = 33;
    localparam int LIT_RECIP       = 65794;
    localparam int LIT_RECIP_SHIFT = 24;
    localparam int LIT_ROUND       = 127;

    localparam logic [HUE_W-1:0] OFFSET_RED   = 9'd0;
    localparam logic [HUE_W-1:0] OFFSET_WRAP  = 9'd360;
    localparam logic [HUE_W-1:0] OFFSET_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] OFFSET_BLUE  = 9'd240;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_RED_WRAP,
        SEC_GREEN,
        SEC_BLUE
    } hue_sector_t;

endpackage

FILE: hdl/rgb_to_hsl.sv
// Top level of the RGB to HSL converter with its front end and output register.
// A pixel passes the input, sum, setup, divider and output registers from start to done.
// Throughput is one pixel per cycle; busy stays low, so a pixel may start every cycle.
// The depth is set by the hue and saturation dividers, which retire one quotient bit per stage.
// The asynchronous active-low reset clears all valid bits; data registers are not reset.
module rgb_to_hsl
    import rth_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CH_W-1:0]        red,
    input  logic [CH_W-1:0]        green,
    input  logic [CH_W-1:0]        blue,
    output logic                   done,
    output logic [HUE_W-1:0]       hue,
    output logic [FRACTION_BITS:0] saturation,
    output logic [FRACTION_BITS:0] lightness
);

    localparam int QUO_W     = FRACTION_BITS + 1;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int LATENCY   = FRACTION_BITS + 5;
    localparam int LIT_SHIFT = (FRACTION_BITS - 1) % 8;
    localparam int LIT_BASE  = ((1 << (FRACTION_BITS - 1)) - (1 << LIT_SHIFT)) / HALF_SUM;

    logic              v1_reg;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;

    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    hue_sector_t       sector;
    logic signed [8:0] sd;

    logic              v2_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CH_W-1:0]   delta_reg;
    hue_sector_t       sector_reg;
    logic signed [8:0] sd_reg;
    logic              gray2_reg;

    logic [CH_W-1:0]    sat_den;
    logic [HUE_W-1:0]   offset;
    logic [16:0]        prod;
    logic signed [16:0] sd60;
    logic signed [17:0] hue_sum;

    logic              v3_reg;
    logic              gray3_reg;
    logic [NUM_W-1:0]  hue_num_reg;
    logic [DEN_W-1:0]  hue_den_reg;
    logic [NUM_W-1:0]  sat_num_reg;
    logic [DEN_W-1:0]  sat_den_reg;
    logic [LIT_X_W-1:0] lit_x_reg;
    logic [QUO_W-1:0]   lit_base_reg;
    logic [LIT_PROD_W-1:0] lit_prod;
    logic [QUO_W-1:0]   lit_pipe_reg [QUO_W];

    logic [QUO_W-1:0]  valid_pipe_reg;
    logic [QUO_W-1:0]  gray_pipe_reg;
    logic [QUO_W-1:0]  hue_q;
    logic [QUO_W-1:0]  sat_q;
    logic [QUO_W-1:0]  lit_q;

    logic                   done_reg;
    logic [HUE_W-1:0]       hue_reg;
    logic [FRACTION_BITS:0] sat_reg;
    logic [FRACTION_BITS:0] lit_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            valid_pipe_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            v1_reg         <= start;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            valid_pipe_reg <= {valid_pipe_reg[QUO_W-2:0], v3_reg};
            done_reg       <= valid_pipe_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    always_comb
    begin
        if (red_reg >= green_reg && red_reg >= blue_reg)
        begin
            mx = red_reg;
            sd = $signed({1'b0, green_reg}) - $signed({1'b0, blue_reg});
            sector = (green_reg >= blue_reg) ? SEC_RED : SEC_RED_WRAP;
        end
        else if (green_reg >= blue_reg)
        begin
            mx = green_reg;
            sd = $signed({1'b0, blue_reg}) - $signed({1'b0, red_reg});
            sector = SEC_GREEN;
        end
        else
        begin
            mx = blue_reg;
            sd = $signed({1'b0, red_reg}) - $signed({1'b0, green_reg});
            sector = SEC_BLUE;
        end
        mn = red_reg;
        if (green_reg < mn)
        begin
            mn = green_reg;
        end
        if (blue_reg < mn)
        begin
            mn = blue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= {1'b0, mx} + {1'b0, mn};
        delta_reg  <= mx - mn;
        sector_reg <= sector;
        sd_reg     <= sd;
        gray2_reg  <= (mx == mn);
    end

    always_comb
    begin
        if (sum_reg <= SUM_W'(HALF_SUM))
        begin
            sat_den = sum_reg[CH_W-1:0];
        end
        else
        begin
            sat_den = CH_W'(SUM_W'(FULL_SUM) - sum_reg);
        end
        case (sector_reg)
            SEC_RED:      offset = OFFSET_RED;
            SEC_RED_WRAP: offset = OFFSET_WRAP;
            SEC_GREEN:    offset = OFFSET_GREEN;
            SEC_BLUE:     offset = OFFSET_BLUE;
            default:      offset = OFFSET_RED;
        endcase
        prod    = 17'(offset) * 17'(delta_reg);
        sd60    = 17'(sd_reg) * 17'sd60;
        hue_sum = $signed({1'b0, prod}) + 18'(sd60);
    end

    always_ff @(posedge clk)
    begin
        gray3_reg    <= gray2_reg;
        hue_num_reg  <= NUM_W'({hue_sum[16:0], 1'b0}) + NUM_W'(delta_reg);
        hue_den_reg  <= DEN_W'({delta_reg, 1'b0});
        sat_num_reg  <= (NUM_W'(delta_reg) << (FRACTION_BITS + 1)) + NUM_W'(sat_den);
        sat_den_reg  <= DEN_W'({sat_den, 1'b0});
        lit_x_reg    <= (LIT_X_W'(sum_reg) << LIT_SHIFT) + LIT_X_W'(LIT_ROUND);
        lit_base_reg <= QUO_W'(sum_reg) * QUO_W'(LIT_BASE);
    end

    rth_div #(.QUO_W(QUO_W)) u_hue_div
    (
        .clk (clk),
        .num (hue_num_reg),
        .den (hue_den_reg),
        .quo (hue_q)
    );

    rth_div #(.QUO_W(QUO_W)) u_sat_div
    (
        .clk (clk),
        .num (sat_num_reg),
        .den (sat_den_reg),
        .quo (sat_q)
    );

    // Lightness is the sum times a whole multiple of 1/255 plus a small remainder
    // divided by 255, which a reciprocal multiply gives exactly.
    assign lit_prod = LIT_PROD_W'(lit_x_reg) * LIT_PROD_W'(LIT_RECIP);

    always_ff @(posedge clk)
    begin
        lit_pipe_reg[0] <= lit_base_reg + QUO_W'(lit_prod[LIT_PROD_W-1:LIT_RECIP_SHIFT]);
        for (int k = 1; k < QUO_W; k++)
        begin
            lit_pipe_reg[k] <= lit_pipe_reg[k-1];
        end
    end

    assign lit_q = lit_pipe_reg[QUO_W-1];

    always_ff @(posedge clk)
    begin
        gray_pipe_reg <= {gray_pipe_reg[QUO_W-2:0], gray3_reg};
        hue_reg       <= gray_pipe_reg[QUO_W-1] ? '0 : hue_q[HUE_W-1:0];
        sat_reg       <= gray_pipe_reg[QUO_W-1] ? '0 : sat_q;
        lit_reg       <= lit_q;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lit_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("Pixel transfer did not produce a result at the expected latency.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("Result strobe without a matching start transfer.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue <= HUE_W'(360) &&
                  saturation <= (FRACTION_BITS+1)'(1 << FRACTION_BITS) &&
                  lightness <= (FRACTION_BITS+1)'(1 << FRACTION_BITS)))
        else $error("Result field out of range.");

endmodule

FILE: hdl/rth_div.sv
// Pipelined restoring divider that retires one quotient bit per stage.
module rth_div
    import rth_pkg::*;
#(
    parameter int QUO_W = 17
)
(
    input  logic                   clk,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic [QUO_W-1:0]       quo
);

    localparam int WORD_W = DEN_W + QUO_W;

    logic [WORD_W-1:0] word_reg [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [WORD_W-1:0] word_in;
        logic [DEN_W-1:0]  den_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic [WORD_W-1:0] word_next;

        if (k == 0) begin : g_first
            assign word_in = num;
            assign den_in  = den;
        end
        else begin : g_rest
            assign word_in = word_reg[k-1];
            assign den_in  = den_reg[k-1];
        end

        always_comb
        begin
            trial = {word_in[WORD_W-1:QUO_W], word_in[QUO_W-1]};
            diff  = trial - {1'b0, den_in};
            if (trial >= {1'b0, den_in})
            begin
                word_next = {diff[DEN_W-1:0], word_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                word_next = {trial[DEN_W-1:0], word_in[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            word_reg[k] <= word_next;
            den_reg[k]  <= den_in;
        end
    end

    assign quo = word_reg[QUO_W-1][QUO_W-1:0];

endmodule

FILE: verif/rgb_to_hsl_tb.sv
// Self-checking testbench for the RGB to HSL converter with a scoreboard of expected pixels.
module rgb_to_hsl_tb;
    import rth_pkg::*;

    localparam int FB             = 16;
    localparam int LATENCY        = FB + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 1750;
    localparam int NUM_PHASES     = 3;
    localparam int NUM_DIRECTED   = 23;
    localparam bit [63:0] SEXTANT = 60;

    localparam bit [3*CH_W-1:0] DIRECTED_RGB [NUM_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFEFEFE,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0001, 24'hFFFF00,
        24'hFF00FF, 24'h00FFFF, 24'h0AFF00, 24'h00FF0A, 24'h0A00FF,
        24'h000AFF, 24'h010000, 24'hFFFEFE, 24'hC73864, 24'hC83864,
        24'hFF7F00, 24'h7F007F, 24'h80FF80
    };

    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{0, 82, 35};

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [FB:0]      sat;
        logic [FB:0]      lit;
    } hsl_t;

    class hsl_checker;
        hsl_t pending_hsl[$];
        int   mismatches;
        int   checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function bit [63:0] round_div(input bit [63:0] num, input bit [63:0] den);
            return (2 * num + den) / (2 * den);
        endfunction

        function hsl_t rgb_to_hsl_value(input logic [CH_W-1:0] r8, g8, b8);
            bit [63:0] r, g, b, mx, mn, sum, dl, den, num, one;
            hsl_t      res;
            r   = 64'(r8);
            g   = 64'(g8);
            b   = 64'(b8);
            one = 64'd1 << FB;
            mx  = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn  = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            sum = mx + mn;
            dl  = mx - mn;
            res.lit = (FB+1)'(round_div(sum * one, FULL_SUM));
            res.hue = '0;
            res.sat = '0;
            if (dl != 0)
            begin
                den     = (sum <= HALF_SUM) ? sum : FULL_SUM - sum;
                res.sat = (FB+1)'(round_div(dl * one, den));
                if (mx == r)
                    num = (g >= b) ? SEXTANT * (g - b)
                                   : OFFSET_WRAP * dl - SEXTANT * (b - g);
                else if (mx == g)
                    num = (b >= r) ? OFFSET_GREEN * dl + SEXTANT * (b - r)
                                   : OFFSET_GREEN * dl - SEXTANT * (r - b);
                else
                    num = (r >= g) ? OFFSET_BLUE * dl + SEXTANT * (r - g)
                                   : OFFSET_BLUE * dl - SEXTANT * (g - r);
                res.hue = HUE_W'(round_div(num, dl));
            end
            return res;
        endfunction

        function void note_pixel(input logic [CH_W-1:0] r, g, b);
            pending_hsl.push_back(rgb_to_hsl_value(r, g, b));
        endfunction

        function void check_pixel(input logic [HUE_W-1:0] h, input logic [FB:0] s, l);
            hsl_t want;
            if (pending_hsl.size() == 0)
            begin
                $error("unexpected result: hue %0d saturation %0d lightness %0d", h, s, l);
                mismatches++;
                return;
            end
            want = pending_hsl.pop_front();
            checked++;
            if (h !== want.hue)
            begin
                $error("hue: expected %0d, actual %0d", want.hue, h);
                mismatches++;
            end
            if (s !== want.sat)
            begin
                $error("saturation: expected %0d, actual %0d", want.sat, s);
                mismatches++;
            end
            if (l !== want.lit)
            begin
                $error("lightness: expected %0d, actual %0d", want.lit, l);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic              done;
    logic [HUE_W-1:0]  hue;
    logic [FB:0]       saturation;
    logic [FB:0]       lightness;

    hsl_checker sb;
    int         pixels_sent  = 0;
    int         quiet_cycles = 0;

    rgb_to_hsl #(.FRACTION_BITS(FB)) DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_pixel(hue, saturation, lightness);
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.", sb.pending_hsl.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input int idle_pct);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            red   = CH_W'($urandom);
            green = CH_W'($urandom);
            blue  = CH_W'($urandom);
            @(negedge clk);
        end
        start = 1'b1;
        red   = r;
        green = g;
        blue  = b;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_pixel(r, g, b);
        pixels_sent++;
    endtask

    task automatic pick_pixel(output logic [CH_W-1:0] r, g, b);
        int              mode;
        int              v;
        logic [CH_W-1:0] t;
        mode = $urandom_range(9);
        r    = CH_W'($urandom);
        g    = CH_W'($urandom);
        b    = CH_W'($urandom);
        case (mode)
            0:
            begin
                g = r;
                b = r;
            end
            1:
            begin
                v = $urandom_range(255);
                r = CH_W'(v);
                g = CH_W'(v);
                b = CH_W'($urandom_range(v));
                case ($urandom_range(2))
                    1:
                    begin
                        t = r;
                        r = b;
                        b = t;
                    end
                    2:
                    begin
                        t = g;
                        g = b;
                        b = t;
                    end
                    default: ;
                endcase
            end
            2:
            begin
                v = $urandom_range(254);
                r = CH_W'(v + $urandom_range(1));
                g = CH_W'(v + $urandom_range(1));
                b = CH_W'(v + $urandom_range(1));
            end
            3:
            begin
                if ($urandom_range(2) == 0) r = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(2) == 0) g = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(2) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        logic [CH_W-1:0] r, g, b;
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        red   = '0;
        green = '0;
        blue  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_RGB[i])
            send_pixel(DIRECTED_RGB[i][23:16], DIRECTED_RGB[i][15:8], DIRECTED_RGB[i][7:0], 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int n = 0; n < RANDOM_PIXELS / NUM_PHASES; n++)
            begin
                pick_pixel(r, g, b);
                send_pixel(r, g, b, PHASE_IDLE_PCT[p]);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.pending_hsl.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("Converted %0d pixels (%0d directed corner cases, then random pixels",
                 pixels_sent, NUM_DIRECTED);
        $display("under %0d pacing phases); %0d results compared, %0d field mismatches.",
                 NUM_PHASES, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_hsl.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
